/* src/iprm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprm_pkg
// Shared constants and types for the interrupt priority mask table.
// ----------------------------------------------------------------------------
package iprm_pkg;

  localparam int NUM_LEVELS   = 16;
  localparam int CASCADE_LINE = 2;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int IN_W   = 4;
  localparam int CMP_W  = ((LVL_W > IN_W) ? LVL_W : IN_W) + 1;
  localparam int WORD_W = 16;
  localparam int MASK_W = 8;

  // master half keeps the cascade line open
  localparam logic [WORD_W-1:0] RESET_WORD =
    16'hff00 | (16'h00ff & ~(16'd1 << CASCADE_LINE));

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DEL = 2'd1;

  typedef struct packed {
    logic              wr_en;
    logic [LVL_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [LVL_W-1:0]  rd_addr;
  } tbl_req_t;

endpackage : iprm_pkg
`default_nettype wire

/* src/interrupt_priority_mask_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_priority_mask_table
// Per-level master/slave interrupt masks with handler add/delete walks.
// ----------------------------------------------------------------------------
// Each beat on the input names a command, a line and a level. Add and delete
// beats walk the level table one entry per cycle through a single read/modify
// unit: an upward walk sets the line's bit until it finds it already set or
// reaches the top level, a downward walk clears it until it finds it already
// clear or reaches level 0. After the walks the masks of the named level are
// read and presented as one result beat (zero masks for a level beyond the
// table). An item passes through accept, the upward and downward walks that
// its command calls for, and the final read and capture of the named level;
// the capture waits while the output holds off. Input stall is high once a
// beat is accepted until the result is loaded into the output register. The
// table comes out of reset ready, with no clearing pass.
// ----------------------------------------------------------------------------
module interrupt_priority_mask_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    cmd,
  input  wire logic [3:0]                    irq_line,
  input  wire logic [3:0]                    level,
  input  wire logic [3:0]                    min_level,
  input  wire logic                          last_handler,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [iprm_pkg::MASK_W-1:0]        master_mask,
  output logic [iprm_pkg::MASK_W-1:0]        slave_mask
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP_RD   = 3'd1;
  localparam logic [2:0] ST_UP_CHK  = 3'd2;
  localparam logic [2:0] ST_DN_RD   = 3'd3;
  localparam logic [2:0] ST_DN_CHK  = 3'd4;
  localparam logic [2:0] ST_OUT_RD  = 3'd5;
  localparam logic [2:0] ST_OUT_CAP = 3'd6;

  localparam logic [iprm_pkg::LVL_W-1:0] LAST_IDX =
    iprm_pkg::LVL_W'(iprm_pkg::NUM_LEVELS - 1);
  localparam logic [iprm_pkg::CMP_W-1:0] NUM_LVL_C =
    iprm_pkg::CMP_W'(iprm_pkg::NUM_LEVELS);

  logic [2:0]                      state, state_next;
  logic [iprm_pkg::LVL_W-1:0]      idx, idx_next;
  logic [iprm_pkg::WORD_W-1:0]     bit_sel;
  logic                            do_down;
  logic [iprm_pkg::LVL_W-1:0]      down_start;
  logic [iprm_pkg::LVL_W-1:0]      rd_level;
  logic                            level_ok;

  iprm_pkg::tbl_req_t              tbl_req;
  logic [iprm_pkg::WORD_W-1:0]     rd_data;

  // decode of the incoming beat
  logic                            in_acc;
  logic [iprm_pkg::CMP_W-1:0]      lvl_ext, min_ext, min_m1;
  logic                            lvl_in;
  logic                            add_go, del_last, del_walk, up_go, dn_go;
  logic [iprm_pkg::LVL_W-1:0]      up_from, dn_from, min_sat;

  // shared read/modify unit
  logic                            hit;
  logic                            out_load;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    lvl_ext  = iprm_pkg::CMP_W'(level);
    min_ext  = iprm_pkg::CMP_W'(min_level);
    min_m1   = min_ext - iprm_pkg::CMP_W'(1);
    lvl_in   = (lvl_ext < NUM_LVL_C);
    // downward walk start saturates at the top level
    min_sat  = (min_m1 >= NUM_LVL_C) ? LAST_IDX : iprm_pkg::LVL_W'(min_m1);
    add_go   = (cmd == iprm_pkg::CMD_ADD) && (level == min_level) && lvl_in;
    del_last = (cmd == iprm_pkg::CMD_DEL) && last_handler;
    del_walk = (cmd == iprm_pkg::CMD_DEL) && !last_handler && (level < min_level);
    up_go    = add_go || del_last;
    dn_go    = (add_go && (level != 4'd0)) || del_walk;
    up_from  = add_go ? iprm_pkg::LVL_W'(level) : '0;
    dn_from  = add_go ? iprm_pkg::LVL_W'(lvl_ext - iprm_pkg::CMP_W'(1)) : min_sat;
  end

  // bit test of the entry being walked
  assign hit = |(rd_data & bit_sel);
  assign out_load = !out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    tbl_req.wr_en   = 1'b0;
    tbl_req.wr_addr = idx;
    tbl_req.wr_data = rd_data;
    tbl_req.rd_addr = idx;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (up_go) begin
            state_next = ST_UP_RD;
            idx_next   = up_from;
          end else if (dn_go) begin
            state_next = ST_DN_RD;
            idx_next   = dn_from;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_UP_RD: begin
        state_next = ST_UP_CHK;
      end
      ST_UP_CHK: begin
        // stop at the first level already masked, or after setting the top level
        if (hit) begin
          state_next = do_down ? ST_DN_RD : ST_OUT_RD;
          idx_next   = down_start;
        end else begin
          tbl_req.wr_en   = 1'b1;
          tbl_req.wr_data = rd_data | bit_sel;
          if (idx == LAST_IDX) begin
            state_next = do_down ? ST_DN_RD : ST_OUT_RD;
            idx_next   = down_start;
          end else begin
            idx_next        = idx + iprm_pkg::LVL_W'(1);
            tbl_req.rd_addr = idx + iprm_pkg::LVL_W'(1);
          end
        end
      end
      ST_DN_RD: begin
        state_next = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        // stop at the first level already clear, or after clearing level 0
        if (!hit) begin
          state_next = ST_OUT_RD;
        end else begin
          tbl_req.wr_en   = 1'b1;
          tbl_req.wr_data = rd_data & ~bit_sel;
          if (idx == '0) begin
            state_next = ST_OUT_RD;
          end else begin
            idx_next        = idx - iprm_pkg::LVL_W'(1);
            tbl_req.rd_addr = idx - iprm_pkg::LVL_W'(1);
          end
        end
      end
      ST_OUT_RD: begin
        tbl_req.rd_addr = rd_level;
        state_next      = ST_OUT_CAP;
      end
      ST_OUT_CAP: begin
        // hold the read address so the data stays while the output drains
        tbl_req.rd_addr = rd_level;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  iprm_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-item context, loaded at accept
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (in_acc) begin
      bit_sel    <= iprm_pkg::WORD_W'(1) << irq_line;
      do_down    <= up_go && dn_go;
      down_start <= dn_from;
      rd_level   <= iprm_pkg::LVL_W'(level);
      level_ok   <= lvl_in;
    end
  end

  // output register, one result beat per item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT_CAP && out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT_CAP && out_load) begin
      master_mask <= level_ok ? rd_data[iprm_pkg::MASK_W-1:0] : '0;
      slave_mask  <= level_ok ? rd_data[iprm_pkg::WORD_W-1:iprm_pkg::MASK_W] : '0;
    end
  end

  // a new result only ever comes out of the capture state
  a_out_from_cap: assert property (@(posedge clk) disable iff (rst)
    (state != ST_OUT_CAP) |=> !$rose(out_valid))
    else $error("result beat raised outside capture");

  // table writes only happen in the walk check states
  a_wr_in_walk: assert property (@(posedge clk) disable iff (rst)
    tbl_req.wr_en |-> (state == ST_UP_CHK || state == ST_DN_CHK))
    else $error("table write outside a walk");

  // upward walk sets the line bit, downward walk clears it
  a_wr_bit: assert property (@(posedge clk) disable iff (rst)
    tbl_req.wr_en |-> ((state == ST_UP_CHK) == ((tbl_req.wr_data & bit_sel) != '0)))
    else $error("walk wrote the wrong bit value");

  // an accepted beat always leaves idle
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != ST_IDLE))
    else $error("accepted beat did not start the sequencer");

endmodule : interrupt_priority_mask_table
`default_nettype wire

/* src/iprm_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprm_table
// Per-level mask storage: one write and one registered read per cycle,
// entries never written since reset read as the reset word.
// ----------------------------------------------------------------------------
module iprm_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire iprm_pkg::tbl_req_t            req,
  output logic [iprm_pkg::WORD_W-1:0]        rd_data
);

  logic [iprm_pkg::WORD_W-1:0]     mem [iprm_pkg::NUM_LEVELS];
  logic [iprm_pkg::NUM_LEVELS-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[req.rd_addr]) begin
      rd_data <= mem[req.rd_addr];
    end else begin
      rd_data <= iprm_pkg::RESET_WORD;
    end
  end

endmodule : iprm_table
`default_nettype wire
